// ===== hdl/afs_pkg.sv =====
// Package for the arm/disarm failsafe block: register indexes, reset values,
// stick margin, timer limit and the configuration struct. No dependencies.
`default_nettype none

package afs_pkg;

   localparam int unsigned StickW   = 11;
   localparam int unsigned TimerW   = 16;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 16;

   localparam logic [StickW-1:0] StickMargin = 11'd10;
   localparam logic [TimerW-1:0] TimerMax    = 16'hFFFF;

   localparam logic [StickW-1:0] ThrLowReset   = 11'd362;
   localparam logic [StickW-1:0] YawHighReset  = 11'd1686;
   localparam logic [TimerW-1:0] LossHoldReset = 16'd1000;
   localparam logic [TimerW-1:0] UnlkHoldReset = 16'd2000;
   localparam logic [TimerW-1:0] LockHoldReset = 16'd10000;

   typedef enum logic [CsrIdxW-1:0] {
      REG_THR_LOW   = 3'd0,
      REG_YAW_HIGH  = 3'd1,
      REG_LOSS_HOLD = 3'd2,
      REG_UNLK_HOLD = 3'd3,
      REG_LOCK_HOLD = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [StickW-1:0] throttle_low_limit;
      logic [StickW-1:0] yaw_high_limit;
      logic [TimerW-1:0] loss_hold_ms;
      logic [TimerW-1:0] unlock_hold_ms;
      logic [TimerW-1:0] lock_hold_ms;
   } cfg_type;

   typedef struct packed {
      logic [TimerW-1:0] elapsed_ms;
      logic              fail_switch_a_down;
      logic              fail_switch_b_down;
      logic [StickW-1:0] throttle_stick;
      logic [StickW-1:0] yaw_stick;
      logic              position_ready;
   } tick_type;

   typedef struct packed {
      logic locked;
      logic signal_lost;
      logic unlock_event;
   } result_type;

   function automatic logic [TimerW-1:0] sat_add(input logic [TimerW-1:0] a,
                                                 input logic [TimerW-1:0] b);
      logic [TimerW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TimerW] ? TimerMax : s[TimerW-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/afs_cfg_regs.sv =====
// Configuration registers of the arm/disarm failsafe block.
// Depends on afs_pkg.
`default_nettype none

module afs_cfg_regs
   import afs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wen,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            REG_THR_LOW:   cfg_in.throttle_low_limit = csr_wdata[StickW-1:0];
            REG_YAW_HIGH:  cfg_in.yaw_high_limit     = csr_wdata[StickW-1:0];
            REG_LOSS_HOLD: cfg_in.loss_hold_ms       = csr_wdata[TimerW-1:0];
            REG_UNLK_HOLD: cfg_in.unlock_hold_ms     = csr_wdata[TimerW-1:0];
            REG_LOCK_HOLD: cfg_in.lock_hold_ms       = csr_wdata[TimerW-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.throttle_low_limit <= ThrLowReset;
         cfg_ff.yaw_high_limit     <= YawHighReset;
         cfg_ff.loss_hold_ms       <= LossHoldReset;
         cfg_ff.unlock_hold_ms     <= UnlkHoldReset;
         cfg_ff.lock_hold_ms       <= LockHoldReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hdl/afs_core.sv =====
// Failsafe and lock state update: timers, flags and the per-tick result.
// Depends on afs_pkg.
`default_nettype none

module afs_core
   import afs_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     fire,
   input  wire cfg_type  cfg,
   input  wire tick_type tick,
   output result_type    result
);

   logic [TimerW-1:0] loss_timer_ff, loss_timer_in;
   logic [TimerW-1:0] unlock_timer_ff, unlock_timer_in;
   logic [TimerW-1:0] relock_timer_ff, relock_timer_in;
   logic              lock_ff, lock_in;
   logic              loss_ff, loss_in;
   logic              unlock_ev;
   logic              thr_low, yaw_high, both_down;
   logic [StickW:0]   thr_limit, yaw_sum;
   logic [TimerW-1:0] loss_sum, unlock_sum, relock_sum;

   always_comb begin
      thr_limit = {1'b0, cfg.throttle_low_limit} + {1'b0, StickMargin};
      yaw_sum   = {1'b0, tick.yaw_stick} + {1'b0, StickMargin};
      thr_low   = {1'b0, tick.throttle_stick} < thr_limit;
      yaw_high  = yaw_sum > {1'b0, cfg.yaw_high_limit};
      both_down = tick.fail_switch_a_down && tick.fail_switch_b_down;

      loss_sum   = sat_add(loss_timer_ff, tick.elapsed_ms);
      unlock_sum = sat_add(unlock_timer_ff, tick.elapsed_ms);
      relock_sum = sat_add(relock_timer_ff, tick.elapsed_ms);

      loss_timer_in   = loss_timer_ff;
      loss_in         = loss_ff;
      unlock_timer_in = unlock_timer_ff;
      relock_timer_in = relock_timer_ff;
      lock_in         = lock_ff;
      unlock_ev       = 1'b0;

      if (both_down) begin
         loss_timer_in = loss_sum;
         if (loss_sum > cfg.loss_hold_ms) begin
            loss_in       = 1'b1;
            loss_timer_in = cfg.loss_hold_ms;
         end
      end else begin
         loss_in       = 1'b0;
         loss_timer_in = '0;
      end

      if (lock_ff) begin
         relock_timer_in = '0;
         if (thr_low && yaw_high && !loss_in && tick.position_ready) begin
            unlock_timer_in = unlock_sum;
            if (unlock_sum > cfg.unlock_hold_ms) begin
               lock_in   = 1'b0;
               unlock_ev = 1'b1;
            end
         end else begin
            unlock_timer_in = '0;
         end
      end else begin
         unlock_timer_in = '0;
         relock_timer_in = thr_low ? relock_sum : '0;
         if (relock_timer_in > cfg.lock_hold_ms) begin
            lock_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loss_timer_ff   <= '0;
         unlock_timer_ff <= '0;
         relock_timer_ff <= '0;
         lock_ff         <= 1'b1;
         loss_ff         <= 1'b0;
      end else if (fire) begin
         loss_timer_ff   <= loss_timer_in;
         unlock_timer_ff <= unlock_timer_in;
         relock_timer_ff <= relock_timer_in;
         lock_ff         <= lock_in;
         loss_ff         <= loss_in;
      end
   end

   assign result.locked       = lock_in;
   assign result.signal_lost  = loss_in;
   assign result.unlock_event = unlock_ev;

`ifndef ASSERT_OFF
   a_unlock_from_locked: assert property (@(posedge clock) disable iff (reset)
      fire && unlock_ev |-> lock_ff && !lock_in)
      else $error("unlock pulse without a locked craft");

   a_release_clears_loss: assert property (@(posedge clock) disable iff (reset)
      fire && !both_down |=> !loss_ff && loss_timer_ff == '0)
      else $error("loss state not cleared on switch release");

   a_locked_clears_relock: assert property (@(posedge clock) disable iff (reset)
      fire && lock_ff |=> relock_timer_ff == '0)
      else $error("relock timer running while locked");

   a_unlocked_clears_unlock: assert property (@(posedge clock) disable iff (reset)
      fire && !lock_ff |=> unlock_timer_ff == '0)
      else $error("unlock timer running while unlocked");
`endif

endmodule

`default_nettype wire

// ===== hdl/arm_disarm_failsafe_fsm.sv =====
// Top level of the arm/disarm failsafe block: input register, state update,
// result register. Depends on afs_pkg, afs_cfg_regs and afs_core.
//
//   channel  direction  handshake                    payload
//   req      in         req_tvalid / req_tready      req_tdata  [40:0] in 48 bits
//   rsp      out        rsp_tvalid / rsp_tready      rsp_tdata  [2:0] in 8 bits
//   csr      in         csr_wen (no wait)            csr_index, csr_wdata
//
// A req passes the input and result registers to rsp; with rsp_tready high, one
// tick per cycle is sustained, set by the single state update between them.
// Reset leaves the craft locked with cleared timers and loss flag.
// A stalled rsp holds its result; the input register still takes one more
// transaction, and req_tready drops only when both registers are full.
`default_nettype none

module arm_disarm_failsafe_fsm
   import afs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   // [15:0] elapsed_ms, [16] fail_switch_a_down, [17] fail_switch_b_down,
   // [28:18] throttle_stick, [39:29] yaw_stick, [40] position_ready, [47:41] zero
   input  wire logic [47:0]         req_tdata,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // [0] locked, [1] signal_lost, [2] unlock_event, [7:3] zero
   output logic [7:0]               rsp_tdata,
   input  wire logic                csr_wen,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata
);

   cfg_type    cfg;
   tick_type   tick_ff, tick_in;
   result_type result, rsp_ff;
   logic       in_valid_ff, out_valid_ff, advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      tick_in.elapsed_ms         = req_tdata[15:0];
      tick_in.fail_switch_a_down = req_tdata[16];
      tick_in.fail_switch_b_down = req_tdata[17];
      tick_in.throttle_stick     = req_tdata[28:18];
      tick_in.yaw_stick          = req_tdata[39:29];
      tick_in.position_ready     = req_tdata[40];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         tick_ff <= tick_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   afs_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   afs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .cfg    (cfg),
      .tick   (tick_ff),
      .result (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_ff.unlock_event, rsp_ff.signal_lost, rsp_ff.locked};

endmodule

`default_nettype wire

// ===== verif/arm_disarm_failsafe_checker.sv =====
// Checker for the arm/disarm failsafe block: watches the csr, req and rsp
// ports, predicts lock/loss/unlock status per tick and compares each rsp.
// Depends on afs_pkg.
module arm_disarm_failsafe_checker
   import afs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic                req_tready,
   input  wire logic [47:0]         req_tdata,
   input  wire logic                rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire logic [7:0]          rsp_tdata,
   input  wire logic                csr_wen,
   input  wire logic [CsrIdxW-1:0]  csr_index,
   input  wire logic [CsrDataW-1:0] csr_wdata,
   output int unsigned              mismatch_count,
   output int unsigned              pending_results
);

   cfg_type           shadow_cfg;
   logic [TimerW-1:0] loss_ms;
   logic [TimerW-1:0] unlock_ms;
   logic [TimerW-1:0] relock_ms;
   logic              is_locked;
   logic              is_lost;
   result_type        expected_status_q[$];
   int unsigned       errors = 0;

   function automatic logic [TimerW-1:0] clamp_add(input logic [TimerW-1:0] a,
                                                   input logic [TimerW-1:0] b);
      logic [TimerW:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[TimerW] ? {TimerW{1'b1}} : sum[TimerW-1:0];
   endfunction

   function automatic result_type advance_failsafe(input tick_type t);
      result_type r;
      logic       thr_low;
      logic       yaw_high;
      thr_low  = int'(t.throttle_stick) < int'(shadow_cfg.throttle_low_limit) + int'(StickMargin);
      yaw_high = int'(t.yaw_stick) > int'(shadow_cfg.yaw_high_limit) - int'(StickMargin);
      r.unlock_event = 1'b0;

      if (t.fail_switch_a_down && t.fail_switch_b_down) begin
         loss_ms = clamp_add(loss_ms, t.elapsed_ms);
         if (loss_ms > shadow_cfg.loss_hold_ms) begin
            is_lost = 1'b1;
            loss_ms = shadow_cfg.loss_hold_ms;
         end
      end else begin
         is_lost = 1'b0;
         loss_ms = '0;
      end

      if (is_locked) begin
         relock_ms = '0;
         if (thr_low && yaw_high && !is_lost && t.position_ready) begin
            unlock_ms = clamp_add(unlock_ms, t.elapsed_ms);
            if (unlock_ms > shadow_cfg.unlock_hold_ms) begin
               is_locked      = 1'b0;
               r.unlock_event = 1'b1;
            end
         end else begin
            unlock_ms = '0;
         end
      end else begin
         unlock_ms = '0;
         relock_ms = thr_low ? clamp_add(relock_ms, t.elapsed_ms) : '0;
         if (relock_ms > shadow_cfg.lock_hold_ms) begin
            is_locked = 1'b1;
         end
      end

      r.locked      = is_locked;
      r.signal_lost = is_lost;
      return r;
   endfunction

   task automatic check_field(input string name, input logic want, input logic got);
      if (want !== got) begin
         $error("%s: expected %0b, got %0b", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      tick_type   tick;
      result_type want;
      if (reset) begin
         shadow_cfg = '{ThrLowReset, YawHighReset, LossHoldReset, UnlkHoldReset, LockHoldReset};
         loss_ms    = '0;
         unlock_ms  = '0;
         relock_ms  = '0;
         is_locked  = 1'b1;
         is_lost    = 1'b0;
         expected_status_q.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               REG_THR_LOW:   shadow_cfg.throttle_low_limit = csr_wdata[StickW-1:0];
               REG_YAW_HIGH:  shadow_cfg.yaw_high_limit     = csr_wdata[StickW-1:0];
               REG_LOSS_HOLD: shadow_cfg.loss_hold_ms       = csr_wdata;
               REG_UNLK_HOLD: shadow_cfg.unlock_hold_ms     = csr_wdata;
               REG_LOCK_HOLD: shadow_cfg.lock_hold_ms       = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            tick.elapsed_ms         = req_tdata[15:0];
            tick.fail_switch_a_down = req_tdata[16];
            tick.fail_switch_b_down = req_tdata[17];
            tick.throttle_stick     = req_tdata[28:18];
            tick.yaw_stick          = req_tdata[39:29];
            tick.position_ready     = req_tdata[40];
            expected_status_q.push_back(advance_failsafe(tick));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_status_q.size() == 0) begin
               $error("rsp transaction with no tick outstanding: tdata %h", rsp_tdata);
               errors++;
            end else begin
               want = expected_status_q.pop_front();
               check_field("locked", want.locked, rsp_tdata[0]);
               check_field("signal_lost", want.signal_lost, rsp_tdata[1]);
               check_field("unlock_event", want.unlock_event, rsp_tdata[2]);
            end
         end
      end
      pending_results <= expected_status_q.size();
      mismatch_count  <= errors;
   end

endmodule

// ===== verif/tb_arm_disarm_failsafe_fsm.sv =====
// Testbench top for arm_disarm_failsafe_fsm: clock, reset, tick stimulus,
// csr writes, rsp back-pressure and verdict. Depends on afs_pkg, the block
// and arm_disarm_failsafe_checker.
module tb_arm_disarm_failsafe_fsm;
   import afs_pkg::*;

   localparam int HoldOffCycles = 200;
   localparam int QuietLimit    = 2000;
   localparam int PhaseCount    = 8;
   localparam int TicksPerPhase = 60;

   typedef enum int {
      BURST_GESTURE,
      BURST_RELOCK,
      BURST_LOSS,
      BURST_NOISE
   } burst_kind_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [47:0]         req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;
   logic                csr_wen    = 1'b0;
   logic [CsrIdxW-1:0]  csr_index  = '0;
   logic [CsrDataW-1:0] csr_wdata  = '0;

   int unsigned mismatch_count;
   int unsigned pending_results;
   int unsigned quiet_cycles  = 0;
   int unsigned rsp_hold_reqs = 0;
   int unsigned rsp_hold_seen = 0;
   int unsigned rsp_hold_left = 0;
   bit          steady_mode   = 1'b0;
   cfg_type     active_cfg    = '{ThrLowReset, YawHighReset, LossHoldReset,
                                    UnlkHoldReset, LockHoldReset};

   arm_disarm_failsafe_fsm u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   arm_disarm_failsafe_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_wen         (csr_wen),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // rsp side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
         rsp_tready    <= 1'b0;
      end else if (rsp_hold_seen != rsp_hold_reqs) begin
         rsp_hold_seen <= rsp_hold_reqs;
         rsp_hold_left <= HoldOffCycles;
         rsp_tready    <= 1'b0;
      end else begin
         rsp_tready <= steady_mode || ($urandom_range(0, 99) >= 19);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QuietLimit) begin
         $display("arm_disarm_failsafe_fsm verification failed");
         $finish;
      end
   end

   function automatic tick_type mk_tick(input int el, input bit a, input bit b,
                                        input int thr, input int yaw, input bit rdy);
      tick_type t;
      t.elapsed_ms         = 16'(el);
      t.fail_switch_a_down = a;
      t.fail_switch_b_down = b;
      t.throttle_stick     = 11'(thr);
      t.yaw_stick          = 11'(yaw);
      t.position_ready     = rdy;
      return t;
   endfunction

   function automatic tick_type random_tick(input burst_kind_type kind);
      tick_type t;
      int       hold;
      int       thr_top;
      int       yaw_bot;
      t       = tick_type'({$urandom, $urandom});
      thr_top = int'(active_cfg.throttle_low_limit) + int'(StickMargin) - 1;
      yaw_bot = int'(active_cfg.yaw_high_limit) - int'(StickMargin) + 1;
      if (thr_top > 2047) thr_top = 2047;
      if (yaw_bot < 0) yaw_bot = 0;
      hold = $urandom_range(0, 65535);
      case (kind)
         BURST_GESTURE: begin
            t.throttle_stick     = 11'($urandom_range(0, thr_top));
            t.yaw_stick          = 11'($urandom_range(yaw_bot, 2047));
            t.position_ready     = $urandom_range(0, 9) != 0;
            t.fail_switch_b_down = t.fail_switch_a_down ? ($urandom_range(0, 7) == 0)
                                                        : ($urandom_range(0, 1) == 1);
            hold = int'(active_cfg.unlock_hold_ms);
         end
         BURST_RELOCK: begin
            t.throttle_stick = 11'($urandom_range(0, thr_top));
            hold = int'(active_cfg.lock_hold_ms);
         end
         BURST_LOSS: begin
            t.fail_switch_a_down = 1'b1;
            t.fail_switch_b_down = 1'b1;
            hold = int'(active_cfg.loss_hold_ms);
         end
         default: ;
      endcase
      case ($urandom_range(0, 19))
         0:       t.elapsed_ms = '1;
         1:       t.elapsed_ms = '0;
         2:       ;
         default: t.elapsed_ms = 16'($urandom_range(0, hold / 3 + 1));
      endcase
      return t;
   endfunction

   task automatic send_tick(input tick_type t);
      while (!steady_mode && $urandom_range(0, 99) < 19) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 48'({$urandom, $urandom});
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, t.position_ready, t.yaw_stick, t.throttle_stick,
                     t.fail_switch_b_down, t.fail_switch_a_down, t.elapsed_ms};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   // mode changes land between edges the rsp process samples on
   task automatic set_mode(input bit steady, input bit hold_off);
      @(posedge clock);
      steady_mode = steady;
      if (hold_off) rsp_hold_reqs++;
      @(negedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      for (int i = 0; i < (1 << CsrIdxW); i++) begin
         csr_index <= CsrIdxW'(i);
         case (i)
            REG_THR_LOW:   csr_wdata <= {5'($urandom), c.throttle_low_limit};
            REG_YAW_HIGH:  csr_wdata <= {5'($urandom), c.yaw_high_limit};
            REG_LOSS_HOLD: csr_wdata <= c.loss_hold_ms;
            REG_UNLK_HOLD: csr_wdata <= c.unlock_hold_ms;
            REG_LOCK_HOLD: csr_wdata <= c.lock_hold_ms;
            default:       csr_wdata <= 16'($urandom);
         endcase
         csr_wen <= 1'b1;
         @(negedge clock);
      end
      csr_wen    <= 1'b0;
      active_cfg = c;
   endtask

   initial begin
      tick_type       directed_ticks[$];
      cfg_type        c;
      burst_kind_type kind;
      int             len;
      int             sent;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // reset limits: throttle low below 372, yaw high above 1676
      directed_ticks.push_back(mk_tick(0, 0, 0, 0, 0, 0));
      directed_ticks.push_back(mk_tick(65535, 1, 1, 2047, 2047, 1));
      directed_ticks.push_back(mk_tick(10, 0, 1, 500, 500, 1));
      directed_ticks.push_back(mk_tick(600, 1, 1, 500, 500, 0));
      directed_ticks.push_back(mk_tick(400, 1, 1, 500, 500, 0));
      directed_ticks.push_back(mk_tick(1, 1, 1, 500, 500, 0));
      directed_ticks.push_back(mk_tick(0, 1, 1, 500, 500, 0));
      directed_ticks.push_back(mk_tick(1500, 1, 1, 0, 2047, 1));
      directed_ticks.push_back(mk_tick(1500, 0, 1, 0, 2047, 1));
      directed_ticks.push_back(mk_tick(1500, 0, 0, 0, 2047, 0));
      directed_ticks.push_back(mk_tick(2000, 1, 0, 371, 1677, 1));
      directed_ticks.push_back(mk_tick(1, 0, 0, 371, 1677, 1));
      directed_ticks.push_back(mk_tick(5000, 0, 0, 372, 0, 0));
      directed_ticks.push_back(mk_tick(10000, 0, 0, 371, 0, 0));
      directed_ticks.push_back(mk_tick(65535, 0, 0, 0, 2047, 1));
      directed_ticks.push_back(mk_tick(3000, 0, 0, 372, 2047, 1));
      directed_ticks.push_back(mk_tick(3000, 0, 0, 0, 1676, 1));
      directed_ticks.push_back(mk_tick(65535, 0, 1, 0, 2047, 1));
      directed_ticks.push_back(mk_tick(65535, 1, 0, 0, 0, 0));
      directed_ticks.push_back(mk_tick(12345, 0, 0, 1024, 1024, 1));
      foreach (directed_ticks[i]) send_tick(directed_ticks[i]);

      for (int phase = 0; phase < PhaseCount; phase++) begin
         wait_drained();
         case (phase)
            0: c = '{ThrLowReset, YawHighReset, LossHoldReset, UnlkHoldReset, LockHoldReset};
            1: c = '{'0, '0, '0, '0, '0};
            2: c = '{'1, '1, '1, '1, '1};
            default: begin
               c.throttle_low_limit = 11'($urandom_range(0, 2047));
               c.yaw_high_limit     = 11'($urandom_range(0, 2047));
               c.loss_hold_ms       = 16'($urandom_range(0, 3) == 0 ? $urandom
                                                                     : $urandom_range(0, 3000));
               c.unlock_hold_ms     = 16'($urandom_range(0, 3) == 0 ? $urandom
                                                                     : $urandom_range(0, 3000));
               c.lock_hold_ms       = 16'($urandom_range(0, 3) == 0 ? $urandom
                                                                     : $urandom_range(0, 3000));
            end
         endcase
         apply_config(c);
         set_mode(phase == 3, phase == 5);
         sent = 0;
         while (sent < TicksPerPhase) begin
            case ($urandom_range(0, 99)) inside
               [0:39]:  kind = BURST_GESTURE;
               [40:64]: kind = BURST_RELOCK;
               [65:79]: kind = BURST_LOSS;
               default: kind = BURST_NOISE;
            endcase
            len = $urandom_range(2, 10);
            for (int j = 0; j < len && sent < TicksPerPhase; j++) begin
               send_tick(random_tick(kind));
               sent++;
            end
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("arm_disarm_failsafe_fsm verification clean");
      end else begin
         $display("arm_disarm_failsafe_fsm verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/afs_pkg.sv
hdl/afs_cfg_regs.sv
hdl/afs_core.sv
hdl/arm_disarm_failsafe_fsm.sv
verif/arm_disarm_failsafe_checker.sv
verif/tb_arm_disarm_failsafe_fsm.sv
